// ----- rtl/edd_pkg.sv -----
// Shared types and constants for the error-diffusion dither block.
// Used by every module under rtl/ except edd_ram; depends on nothing.
`default_nettype none

package edd_pkg;

	// Frame geometry
	localparam int MAX_WIDTH    = 128;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int HEIGHT_LIMIT = 1024;
	localparam int ROW_W        = $clog2(HEIGHT_LIMIT);

	// Field and register widths
	localparam int PIX_W        = 8;
	localparam int ERR_W        = 7;
	localparam int SHARE_W      = ERR_W - 1;
	localparam int BELOW_W      = 8;
	localparam int SUM_W        = PIX_W + 2;
	localparam int FW_REG_W     = 8;
	localparam int FH_REG_W     = 11;
	localparam int APB_DATA_W   = 32;
	localparam int APB_ADDR_W   = 3;

	// Reset values of the configuration registers
	localparam logic [FW_REG_W-1:0] FRAME_WIDTH_RST  = FW_REG_W'(96);
	localparam logic [FH_REG_W-1:0] FRAME_HEIGHT_RST = FH_REG_W'(68);

	// Register indexes (bit 2 of the byte address)
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// Quantizer constants
	localparam logic [PIX_W-1:0] LEVEL_MAX = PIX_W'(255);

	// Output queue
	localparam int OFIFO_DEPTH = 3;
	localparam int OFIFO_PTR_W = 2;
	localparam int OFIFO_CNT_W = 2;

	// Geometry in use: index of the last column and of the last row
	typedef struct packed {
		logic [COL_W-1:0] width_last;
		logic [ROW_W-1:0] height_last;
	} edd_geom_t;

	// One finished pixel
	typedef struct packed {
		logic level;
		logic frame_last;
	} edd_res_t;

endpackage

`default_nettype wire

// ----- rtl/edd_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module edd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, returns old data on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/edd_cfg.sv -----
// APB register file for frame width and height, with clamping to the usable range.
// Depends on edd_pkg.
`default_nettype none

module edd_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [edd_pkg::APB_ADDR_W-1:0]      paddr,
	input  wire logic [edd_pkg::APB_DATA_W-1:0]      pwdata,
	output      logic [edd_pkg::APB_DATA_W-1:0]      prdata,
	output      logic                                pready,
	output      edd_pkg::edd_geom_t                  geom
);

	logic [edd_pkg::FW_REG_W-1:0] frame_width_q;
	logic [edd_pkg::FH_REG_W-1:0] frame_height_q;
	logic                         wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= edd_pkg::FRAME_WIDTH_RST;
			frame_height_q <= edd_pkg::FRAME_HEIGHT_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				edd_pkg::REG_FRAME_WIDTH: begin
					frame_width_q <= pwdata[edd_pkg::FW_REG_W-1:0];
				end
				edd_pkg::REG_FRAME_HEIGHT: begin
					frame_height_q <= pwdata[edd_pkg::FH_REG_W-1:0];
				end
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (paddr[2])
			edd_pkg::REG_FRAME_WIDTH: begin
				prdata = edd_pkg::APB_DATA_W'(frame_width_q);
			end
			edd_pkg::REG_FRAME_HEIGHT: begin
				prdata = edd_pkg::APB_DATA_W'(frame_height_q);
			end
		endcase
	end

	// Clamp width to 2..MAX_WIDTH, give index of the last column
	always_comb begin
		if (frame_width_q < edd_pkg::FW_REG_W'(2)) begin
			geom.width_last = edd_pkg::COL_W'(1);
		end else if (frame_width_q > edd_pkg::FW_REG_W'(edd_pkg::MAX_WIDTH)) begin
			geom.width_last = edd_pkg::COL_W'(edd_pkg::MAX_WIDTH - 1);
		end else begin
			geom.width_last = edd_pkg::COL_W'(frame_width_q - edd_pkg::FW_REG_W'(1));
		end
	end

	// Clamp height to 2..HEIGHT_LIMIT, give index of the last row
	always_comb begin
		if (frame_height_q < edd_pkg::FH_REG_W'(2)) begin
			geom.height_last = edd_pkg::ROW_W'(1);
		end else if (frame_height_q > edd_pkg::FH_REG_W'(edd_pkg::HEIGHT_LIMIT)) begin
			geom.height_last = edd_pkg::ROW_W'(edd_pkg::HEIGHT_LIMIT - 1);
		end else begin
			geom.height_last = edd_pkg::ROW_W'(frame_height_q - edd_pkg::FH_REG_W'(1));
		end
	end

endmodule

`default_nettype wire

// ----- rtl/edd_core.sv -----
// Dither datapath: raster counters, line error memory with read-modify-write
// through a pending-entry register, threshold and error split. Depends on edd_pkg, edd_ram.
`default_nettype none

module edd_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire edd_pkg::edd_geom_t             geom,
	input  wire logic                           accept,
	input  wire logic [edd_pkg::PIX_W-1:0]      pixel_in,
	output      logic                           res_valid,
	output      edd_pkg::edd_res_t              res
);

	// Front counters
	logic [edd_pkg::COL_W-1:0]   col_q;
	logic [edd_pkg::ROW_W-1:0]   row_q;
	logic                        last_col;
	logic                        last_row;

	// Compute stage
	logic                        valid_s1;
	logic [edd_pkg::PIX_W-1:0]   pix_s1;
	logic [edd_pkg::COL_W-1:0]   col_s1;
	logic                        col_zero_s1;
	logic                        row_zero_s1;
	logic                        last_col_s1;
	logic                        last_row_s1;
	logic                        fwd_s1;
	logic [edd_pkg::BELOW_W-1:0] fwd_data_s1;

	// Carried error and pending line-memory entry
	logic [edd_pkg::ERR_W-1:0]   right_q;
	logic                        pend_valid_q;
	logic [edd_pkg::COL_W-1:0]   pend_col_q;
	logic [edd_pkg::SHARE_W-1:0] pend_val_q;

	// Memory ports
	logic                        wr_en;
	logic [edd_pkg::BELOW_W-1:0] wr_data;
	logic [edd_pkg::BELOW_W-1:0] rd_data;

	// Datapath
	logic [edd_pkg::BELOW_W-1:0] below;
	logic [edd_pkg::SUM_W-1:0]   sum;
	logic [edd_pkg::PIX_W-1:0]   sat;
	logic [edd_pkg::ERR_W-1:0]   err;
	logic [edd_pkg::SHARE_W-1:0] share;
	logic                        add_share;

	assign last_col = (col_q >= geom.width_last);
	assign last_row = (row_q >= geom.height_last);

	// Advance raster position on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + edd_pkg::ROW_W'(1);
			end else begin
				col_q <= col_q + edd_pkg::COL_W'(1);
			end
		end
	end

	edd_ram #(
		.WIDTH (edd_pkg::BELOW_W),
		.DEPTH (edd_pkg::MAX_WIDTH)
	) u_below_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (pend_col_q),
		.wdata (wr_data),
		.re    (accept),
		.raddr (col_q),
		.rdata (rd_data)
	);

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Stage 1 payload; catch a write landing on the entry being read
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= pixel_in;
			col_s1      <= col_q;
			col_zero_s1 <= (col_q == '0);
			row_zero_s1 <= (row_q == '0);
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
			fwd_s1      <= wr_en && (pend_col_q == col_q);
			fwd_data_s1 <= wr_data;
		end
	end

	// Sum, saturate, threshold, split the remainder
	always_comb begin
		if (row_zero_s1) begin
			below = '0;
		end else if (fwd_s1) begin
			below = fwd_data_s1;
		end else begin
			below = rd_data;
		end
		sum = edd_pkg::SUM_W'(pix_s1) + edd_pkg::SUM_W'(right_q) + edd_pkg::SUM_W'(below);
		if (sum > edd_pkg::SUM_W'(edd_pkg::LEVEL_MAX)) begin
			sat = edd_pkg::LEVEL_MAX;
		end else begin
			sat = sum[edd_pkg::PIX_W-1:0];
		end
		err   = sat[edd_pkg::ERR_W-1:0];
		share = last_col_s1 ? err[edd_pkg::ERR_W-1:1]
		                    : edd_pkg::SHARE_W'(err[edd_pkg::ERR_W-1:2]);
	end

	// Retire pending entry, adding this pixel's below-left share
	assign add_share = !col_zero_s1 && !last_row_s1;
	assign wr_en     = valid_s1 && pend_valid_q;
	assign wr_data   = edd_pkg::BELOW_W'(pend_val_q)
	                 + (add_share ? edd_pkg::BELOW_W'(share) : '0);

	// Update carried error and pending entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_q      <= '0;
			pend_valid_q <= 1'b0;
			pend_col_q   <= '0;
			pend_val_q   <= '0;
		end else if (valid_s1) begin
			if (last_col_s1) begin
				right_q <= '0;
			end else if (last_row_s1) begin
				right_q <= err;
			end else begin
				right_q <= edd_pkg::ERR_W'(err[edd_pkg::ERR_W-1:1]);
			end
			pend_valid_q <= !last_row_s1;
			pend_col_q   <= col_s1;
			pend_val_q   <= share;
		end
	end

	assign res_valid      = valid_s1;
	assign res.level      = sat[edd_pkg::PIX_W-1];
	assign res.frame_last = last_col_s1 && last_row_s1;

endmodule

`default_nettype wire

// ----- rtl/edd_ofifo.sv -----
// Three-entry result queue between the datapath and the output channel.
// Depends on edd_pkg.
`default_nettype none

module edd_ofifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire edd_pkg::edd_res_t   push_data,
	input  wire logic                pop,
	output      logic                not_empty,
	output      logic                near_full,
	output      edd_pkg::edd_res_t   head
);

	edd_pkg::edd_res_t                entry_q [edd_pkg::OFIFO_DEPTH];
	logic [edd_pkg::OFIFO_PTR_W-1:0]  wr_ptr_q;
	logic [edd_pkg::OFIFO_PTR_W-1:0]  rd_ptr_q;
	logic [edd_pkg::OFIFO_CNT_W-1:0]  cnt_q;
	logic [edd_pkg::OFIFO_CNT_W:0]    cnt_ahead;

	assign not_empty = (cnt_q != '0);
	assign head      = entry_q[rd_ptr_q];

	// Hold off input when queued plus in-flight results fill the queue
	assign cnt_ahead = (edd_pkg::OFIFO_CNT_W+1)'(cnt_q) + (edd_pkg::OFIFO_CNT_W+1)'(push);
	assign near_full = (cnt_ahead >= (edd_pkg::OFIFO_CNT_W+1)'(edd_pkg::OFIFO_DEPTH));

	// Store entry
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == edd_pkg::OFIFO_PTR_W'(edd_pkg::OFIFO_DEPTH - 1))
				          ? '0 : wr_ptr_q + edd_pkg::OFIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == edd_pkg::OFIFO_PTR_W'(edd_pkg::OFIFO_DEPTH - 1))
				          ? '0 : rd_ptr_q + edd_pkg::OFIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + edd_pkg::OFIFO_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - edd_pkg::OFIFO_CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/error_diffusion_dither_unit.sv -----
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+----------------------------------
// pixel in  | in        | in_valid / in_stall   | pixel_in[7:0]
// result    | out       | out_valid / out_stall | level_out[7:0], frame_last
// config    | in        | APB psel/penable      | paddr[2:0], pwdata[31:0], prdata
//
// One pixel per cycle sustained while in_stall is low; each is registered in stage 1,
// then queued. The line error memory (one read, one write a cycle) sets the rate.
// Reset clears counters, carried error and the queue; the line memory is not cleared
// since the first row never reads it. A three-entry result queue absorbs output stalls;
// in_stall rises when queued results plus the one in flight would fill it.
// Top level of the dither block. Depends on edd_pkg, edd_cfg, edd_core, edd_ofifo.
`default_nettype none

module error_diffusion_dither_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// pixel input
	input  wire logic                              in_valid,
	output      logic                              in_stall,
	input  wire logic [edd_pkg::PIX_W-1:0]         pixel_in,
	// result output
	output      logic                              out_valid,
	input  wire logic                              out_stall,
	output      logic [edd_pkg::PIX_W-1:0]         level_out,
	output      logic                              frame_last,
	// configuration
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [edd_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [edd_pkg::APB_DATA_W-1:0]    pwdata,
	output      logic [edd_pkg::APB_DATA_W-1:0]    prdata,
	output      logic                              pready
);

	edd_pkg::edd_geom_t geom;
	edd_pkg::edd_res_t  res;
	edd_pkg::edd_res_t  head;
	logic               res_valid;
	logic               accept;
	logic               pop;

	assign accept = in_valid && !in_stall;
	assign pop    = out_valid && !out_stall;

	edd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.geom    (geom)
	);

	edd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.accept    (accept),
		.pixel_in  (pixel_in),
		.res_valid (res_valid),
		.res       (res)
	);

	edd_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (pop),
		.not_empty (out_valid),
		.near_full (in_stall),
		.head      (head)
	);

	// Expand the one-bit level to 0 or 255
	assign level_out  = {edd_pkg::PIX_W{head.level}};
	assign frame_last = head.frame_last;

endmodule

`default_nettype wire
